/* hdl/fpst_pkg.sv */
// ----------------------------------------------------------------------------
// fpst_pkg: shared types and constants for the prefix sum tree
// Sizes, request format, mode codes and back-end state encoding.
// ----------------------------------------------------------------------------
package fpst_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int NODE_W      = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W       = 11;
    localparam int SIZE_W      = 11;
    localparam int AMT_W       = 32;
    localparam int SUM_W       = 64;
    localparam int CMP_W       = ((NODE_W > POS_W) ? NODE_W : POS_W) + 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        MODE_ADD   = 1'b0,
        MODE_QUERY = 1'b1
    } t_mode;

    // One unit of work handed from front to back
    typedef struct packed {
        t_mode                   mode;
        logic [NODE_W-1:0]       node;
        logic [NODE_W-1:0]       limit;
        logic signed [AMT_W-1:0] amount;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

/* hdl/fenwick_prefix_sum_tree.sv */
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_tree: binary indexed tree of 64-bit partial sums
// Flow: a request waits in the queue until the back end is idle; a query
//   result is registered once the walk ends and the output register is free.
// Work: the back end walks one request at a time, the queue holding up to four
//   more; the single read port of the node memory visits one node per cycle.
// Reset: a sweep zeroes all 1024 node memory words; input stalls meanwhile.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_tree (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [fpst_pkg::SIZE_W-1:0]       i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [fpst_pkg::POS_W-1:0]        i_position,
    input  logic signed [fpst_pkg::AMT_W-1:0] i_amount,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [fpst_pkg::SUM_W-1:0] o_prefix_total
);

    fpst_pkg::t_req      req;
    fpst_pkg::t_req      head;
    fpst_pkg::t_q_status q_status;
    logic                push;
    logic                pop;
    logic                clearing;

    fpst_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_amount      (i_amount),
        .i_clearing    (clearing),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_req         (req)
    );

    fpst_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_req    (req),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    fpst_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_prefix_total (o_prefix_total)
    );

endmodule

/* hdl/fpst_front.sv */
// ----------------------------------------------------------------------------
// fpst_front: request intake and classification
// Holds the size register, computes the starting node, drops dead adds.
// ----------------------------------------------------------------------------
module fpst_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [fpst_pkg::SIZE_W-1:0]       i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [fpst_pkg::POS_W-1:0]        i_position,
    input  logic signed [fpst_pkg::AMT_W-1:0] i_amount,
    input  logic                              i_clearing,
    input  fpst_pkg::t_q_status               i_q_status,
    output logic                              o_push,
    output fpst_pkg::t_req                    o_req
);

    logic [fpst_pkg::SIZE_W-1:0] r_size_in_use;
    logic [fpst_pkg::CMP_W-1:0]  size_ext;
    logic [fpst_pkg::CMP_W-1:0]  cap_ext;
    logic [fpst_pkg::CMP_W-1:0]  eff_ext;
    logic [fpst_pkg::CMP_W-1:0]  pos_ext;
    logic [fpst_pkg::CMP_W-1:0]  add_node;
    logic [fpst_pkg::CMP_W-1:0]  qry_node;
    logic                        add_live;
    logic                        accept;
    fpst_pkg::t_mode             mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_in_use <= fpst_pkg::SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_size_in_use <= i_cfg_wr_data;
        end
    end

    always_comb begin
        mode     = fpst_pkg::t_mode'(i_mode);
        size_ext = fpst_pkg::CMP_W'(r_size_in_use);
        cap_ext  = fpst_pkg::CMP_W'(fpst_pkg::MAX_ENTRIES);
        eff_ext  = (size_ext > cap_ext) ? cap_ext : size_ext;
        pos_ext  = fpst_pkg::CMP_W'(i_position);
        add_node = pos_ext + fpst_pkg::CMP_W'(1);
        qry_node = (pos_ext > eff_ext) ? eff_ext : pos_ext;
        // an add past the covered range touches nothing
        add_live = (add_node <= eff_ext);

        o_in_stall = i_clearing || i_q_status.full;
        accept     = i_in_valid && !o_in_stall;

        o_req.mode   = mode;
        o_req.limit  = fpst_pkg::NODE_W'(eff_ext);
        o_req.amount = i_amount;
        if (mode == fpst_pkg::MODE_ADD) begin
            o_req.node = fpst_pkg::NODE_W'(add_node);
            o_push     = accept && add_live;
        end else begin
            o_req.node = fpst_pkg::NODE_W'(qry_node);
            o_push     = accept;
        end
    end

endmodule

/* hdl/fpst_queue.sv */
// ----------------------------------------------------------------------------
// fpst_queue: request queue between front and back
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module fpst_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  fpst_pkg::t_req       i_req,
    input  logic                 i_pop,
    output fpst_pkg::t_req       o_head,
    output fpst_pkg::t_q_status  o_status
);

    fpst_pkg::t_req                r_slots [fpst_pkg::QUEUE_DEPTH];
    logic [fpst_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [fpst_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [fpst_pkg::QPTR_W:0]     r_count;
    logic                          do_push;
    logic                          do_pop;

    always_comb begin
        o_status.full  = (r_count == (fpst_pkg::QPTR_W + 1)'(fpst_pkg::QUEUE_DEPTH));
        o_status.empty = (r_count == '0);
        do_push        = i_push && !o_status.full;
        do_pop         = i_pop && !o_status.empty;
        o_head         = r_slots[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == fpst_pkg::QPTR_W'(fpst_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_ptr + fpst_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == fpst_pkg::QPTR_W'(fpst_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_ptr + fpst_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (fpst_pkg::QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (fpst_pkg::QPTR_W + 1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (fpst_pkg::QPTR_W + 1)'(fpst_pkg::QUEUE_DEPTH))
        else $error("request queue count beyond depth");

    a_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full && i_push && !i_pop |=> o_status.full)
        else $error("full queue lost its occupancy");

endmodule

/* hdl/fpst_back.sv */
// ----------------------------------------------------------------------------
// fpst_back: tree walker
// Owns the node memory, walks the lowest-set-bit path one node per cycle,
// runs the clearing sweep after reset and holds the result register.
// ----------------------------------------------------------------------------
module fpst_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fpst_pkg::t_req                    i_head,
    input  fpst_pkg::t_q_status               i_q_status,
    output logic                              o_pop,
    output logic                              o_clearing,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [fpst_pkg::SUM_W-1:0] o_prefix_total
);

    logic [fpst_pkg::SUM_W-1:0]  r_mem [fpst_pkg::MAX_ENTRIES];
    logic [fpst_pkg::SUM_W-1:0]  r_rdata;

    fpst_pkg::t_state            r_state, n_state;
    logic [fpst_pkg::ADDR_W-1:0] r_clr_addr, n_clr_addr;
    fpst_pkg::t_mode             r_mode, n_mode;
    logic [fpst_pkg::NODE_W-1:0] r_node, n_node;
    logic [fpst_pkg::NODE_W-1:0] r_limit, n_limit;
    logic [fpst_pkg::SUM_W-1:0]  r_delta, n_delta;
    logic [fpst_pkg::SUM_W-1:0]  r_total, n_total;
    logic                        r_pend, n_pend;
    logic [fpst_pkg::ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic                        r_out_valid, n_out_valid;
    logic [fpst_pkg::SUM_W-1:0]  r_out_data, n_out_data;

    logic                        mem_we;
    logic [fpst_pkg::ADDR_W-1:0] mem_waddr;
    logic [fpst_pkg::SUM_W-1:0]  mem_wdata;
    logic                        mem_re;
    logic [fpst_pkg::ADDR_W-1:0] mem_raddr;

    logic [fpst_pkg::NODE_W-1:0] lsb;
    logic [fpst_pkg::NODE_W:0]   climb;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpst_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_node      <= n_node;
        r_limit     <= n_limit;
        r_delta     <= n_delta;
        r_total     <= n_total;
        r_pend_addr <= n_pend_addr;
        r_out_data  <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_mode      = r_mode;
        n_node      = r_node;
        n_limit     = r_limit;
        n_delta     = r_delta;
        n_total     = r_total;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_pend_addr;
        mem_wdata   = r_rdata + r_delta;
        mem_re      = 1'b0;
        mem_raddr   = fpst_pkg::ADDR_W'(r_node - fpst_pkg::NODE_W'(1));

        lsb   = r_node & fpst_pkg::NODE_W'(~r_node + fpst_pkg::NODE_W'(1));
        climb = {1'b0, r_node} + {1'b0, lsb};

        // read data for the node issued last cycle
        if (r_pend) begin
            if (r_mode == fpst_pkg::MODE_ADD) begin
                mem_we = 1'b1;
            end else begin
                n_total = r_total + r_rdata;
            end
        end

        unique case (r_state)
            fpst_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + fpst_pkg::ADDR_W'(1);
                if (r_clr_addr == fpst_pkg::ADDR_W'(fpst_pkg::MAX_ENTRIES - 1)) begin
                    n_state = fpst_pkg::ST_IDLE;
                end
            end
            fpst_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_mode  = i_head.mode;
                    n_node  = i_head.node;
                    n_limit = i_head.limit;
                    n_delta = fpst_pkg::SUM_W'(i_head.amount);
                    n_total = '0;
                    n_state = fpst_pkg::ST_WALK;
                end
            end
            fpst_pkg::ST_WALK: begin
                // node zero marks the end of the path in both directions
                if (r_node == '0) begin
                    n_state = fpst_pkg::ST_DONE;
                end else begin
                    mem_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = mem_raddr;
                    if (r_mode == fpst_pkg::MODE_ADD) begin
                        n_node = (climb <= {1'b0, r_limit})
                               ? fpst_pkg::NODE_W'(climb) : '0;
                    end else begin
                        n_node = r_node - lsb;
                    end
                end
            end
            fpst_pkg::ST_DONE: begin
                if (r_mode == fpst_pkg::MODE_ADD) begin
                    n_state = fpst_pkg::ST_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_total;
                    n_state     = fpst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpst_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_clearing     = (r_state == fpst_pkg::ST_CLEAR);
    assign o_out_valid    = r_out_valid;
    assign o_prefix_total = r_out_data;

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fpst_pkg::ST_CLEAR |-> !r_out_valid)
        else $error("result present during clearing sweep");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && r_mode == fpst_pkg::MODE_ADD |-> {1'b0, r_pend_addr} < r_limit)
        else $error("tree write beyond size in use");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fpst_pkg::ST_DONE |-> !r_pend)
        else $error("node read still in flight at completion");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == fpst_pkg::ST_WALK)
        else $error("request popped outside idle");

endmodule
